// ----- sv/tpc_pkg.sv -----
`timescale 1ns / 1ps

package tpc_pkg;

    typedef struct packed {
        logic [7:0] shade;
        logic [7:0] highlight;
        logic [7:0] coverage;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_pixel_out;

    typedef struct packed {
        logic [7:0] tint_red;
        logic [7:0] tint_green;
        logic [7:0] tint_blue;
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
        logic       disabled_look;
        logic [1:0] output_mode;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_TINT_RED      = 3'd0,
        REG_TINT_GREEN    = 3'd1,
        REG_TINT_BLUE     = 3'd2,
        REG_BACK_RED      = 3'd3,
        REG_BACK_GREEN    = 3'd4,
        REG_BACK_BLUE     = 3'd5,
        REG_DISABLED_LOOK = 3'd6,
        REG_OUTPUT_MODE   = 3'd7
    } t_reg_idx;

    localparam logic [1:0] MODE_OPAQUE = 2'd0;
    localparam logic [1:0] MODE_KEEP   = 2'd1;
    localparam logic [1:0] MODE_BLEND  = 2'd2;

    localparam int ADDR_W = 5;

endpackage

// ----- sv/tpc_regs.sv -----
`timescale 1ns / 1ps

module tpc_regs import tpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_TINT_RED:      n_cfg.tint_red      = pwdata[7:0];
                REG_TINT_GREEN:    n_cfg.tint_green    = pwdata[7:0];
                REG_TINT_BLUE:     n_cfg.tint_blue     = pwdata[7:0];
                REG_BACK_RED:      n_cfg.back_red      = pwdata[7:0];
                REG_BACK_GREEN:    n_cfg.back_green    = pwdata[7:0];
                REG_BACK_BLUE:     n_cfg.back_blue     = pwdata[7:0];
                REG_DISABLED_LOOK: n_cfg.disabled_look = pwdata[0];
                REG_OUTPUT_MODE:   n_cfg.output_mode   = pwdata[1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TINT_RED:      prdata = {24'd0, r_cfg.tint_red};
            REG_TINT_GREEN:    prdata = {24'd0, r_cfg.tint_green};
            REG_TINT_BLUE:     prdata = {24'd0, r_cfg.tint_blue};
            REG_BACK_RED:      prdata = {24'd0, r_cfg.back_red};
            REG_BACK_GREEN:    prdata = {24'd0, r_cfg.back_green};
            REG_BACK_BLUE:     prdata = {24'd0, r_cfg.back_blue};
            REG_DISABLED_LOOK: prdata = {31'd0, r_cfg.disabled_look};
            REG_OUTPUT_MODE:   prdata = {30'd0, r_cfg.output_mode};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- sv/tinted_pixel_colorizer.sv -----
`timescale 1ns / 1ps

// Tints a stream of pixels with a configured color, then sends the result opaque,
// with its coverage kept as alpha, or blended over a background color. One pixel
// enters per cycle while o_in_stall is low, and its result leaves through a five-stage
// pipeline (tint prep, tint and highlight multiply, round and saturate, blend
// multiply, blend sum). Each stage carries its own valid bit and refills while a
// later stage is stalled, so empty stages are squeezed out and o_in_stall rises
// only when all five stages hold a pixel and the output is stalled. Write the
// registers only while the pipeline is empty.

module tinted_pixel_colorizer import tpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_pixel_in         i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_pixel_out        o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg w_cfg;

    logic [4:0] r_v;
    logic [4:0] w_en;

    logic [2:0][8:0]  r_a_tint;
    logic [7:0]       r_a_gray;
    t_pixel_in        r_a_pix;

    logic [2:0][16:0] r_b_prod;
    logic [8:0]       r_b_add;
    logic [7:0]       r_b_cov;

    logic [2:0][7:0]  r_c_col;
    logic [7:0]       r_c_cov;

    logic [2:0][15:0] r_d_ca;
    logic [2:0][16:0] r_d_ba;
    logic [2:0][7:0]  r_d_col;
    logic [7:0]       r_d_cov;

    t_pixel_out       r_out;

    logic [2:0][7:0]  w_tint;
    logic [2:0][7:0]  w_back;
    logic [12:0]      w_gray_sum;
    logic [7:0]       w_gray;
    logic [2:0][8:0]  n_a_tint;
    logic [2:0][9:0]  w_dis;
    logic [2:0][16:0] n_b_prod;
    logic [8:0]       n_b_add;
    logic [15:0]      w_hg;
    logic [10:0]      w_h5;
    logic [2:0][7:0]  n_c_col;
    logic [2:0][17:0] w_rnd;
    logic [2:0][10:0] w_sum;
    logic [8:0]       w_inv;
    logic [2:0][15:0] n_d_ca;
    logic [2:0][16:0] n_d_ba;
    logic [2:0][16:0] w_ca_r;
    logic [2:0][17:0] w_ba_r;
    logic [2:0][9:0]  w_bl;
    t_pixel_out       n_out;

    tpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_tint = {w_cfg.tint_blue, w_cfg.tint_green, w_cfg.tint_red};
    assign w_back = {w_cfg.back_blue, w_cfg.back_green, w_cfg.back_red};

    always_comb begin
        w_en[4] = !r_v[4] || !i_out_stall;
        for (int k = 3; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_v[4];
    assign o_out_data  = r_out;

    // tint prep
    always_comb begin
        w_gray_sum = 13'(w_cfg.tint_red) * 13'd11 + 13'(w_cfg.tint_green) * 13'd16
                   + 13'(w_cfg.tint_blue) * 13'd5;
        w_gray     = w_gray_sum[12:5];
        for (int c = 0; c < 3; c++) begin
            w_dis[c] = 10'(w_tint[c]) * 10'd3 + 10'(w_gray);
            if (w_cfg.disabled_look) begin
                n_a_tint[c] = {1'b0, w_dis[c][9:2]};
            end else begin
                n_a_tint[c] = 9'(w_tint[c]) + 9'd2;
            end
        end
    end

    // tint and highlight multiply
    always_comb begin
        w_hg = 16'(r_a_pix.highlight) * 16'(r_a_gray) + 16'd127;
        w_h5 = 11'(r_a_pix.highlight) * 11'd5;
        if (w_cfg.disabled_look) begin
            n_b_add = {1'b0, w_hg[15:8]};
        end else if (r_a_pix.shade != 8'd0) begin
            n_b_add = w_h5[10:2];
        end else begin
            n_b_add = {1'b0, r_a_pix.highlight};
        end
        for (int c = 0; c < 3; c++) begin
            n_b_prod[c] = 17'(r_a_tint[c]) * 17'(r_a_pix.shade);
        end
    end

    // round and saturate
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_rnd[c] = 18'(r_b_prod[c]) + 18'd127;
            w_sum[c] = 11'(w_rnd[c][17:8]) + 11'(r_b_add);
            n_c_col[c] = (w_sum[c] > 11'd255) ? 8'hFF : w_sum[c][7:0];
        end
    end

    // blend multiply
    always_comb begin
        w_inv = 9'd256 - 9'(r_c_cov);
        for (int c = 0; c < 3; c++) begin
            n_d_ca[c] = 16'(r_c_col[c]) * 16'(r_c_cov);
            n_d_ba[c] = 17'(w_back[c]) * 17'(w_inv);
        end
    end

    // blend sum and output select
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ca_r[c] = 17'(r_d_ca[c]) + 17'd127;
            w_ba_r[c] = 18'(r_d_ba[c]) + 18'd127;
            w_bl[c]   = 10'(w_ca_r[c][16:8]) + w_ba_r[c][17:8];
        end
        n_out.out_red   = r_d_col[0];
        n_out.out_green = r_d_col[1];
        n_out.out_blue  = r_d_col[2];
        n_out.out_alpha = 8'hFF;
        case (w_cfg.output_mode)
            MODE_KEEP: begin
                n_out.out_alpha = r_d_cov;
            end
            MODE_BLEND: begin
                n_out.out_red   = w_bl[0][7:0];
                n_out.out_green = w_bl[1][7:0];
                n_out.out_blue  = w_bl[2][7:0];
            end
            default: begin
                n_out.out_alpha = 8'hFF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < 5; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a_tint <= n_a_tint;
            r_a_gray <= w_gray;
            r_a_pix  <= i_in_data;
        end
        if (w_en[1]) begin
            r_b_prod <= n_b_prod;
            r_b_add  <= n_b_add;
            r_b_cov  <= r_a_pix.coverage;
        end
        if (w_en[2]) begin
            r_c_col <= n_c_col;
            r_c_cov <= r_b_cov;
        end
        if (w_en[3]) begin
            r_d_ca  <= n_d_ca;
            r_d_ba  <= n_d_ba;
            r_d_col <= r_c_col;
            r_d_cov <= r_c_cov;
        end
        if (w_en[4]) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- sv/tpc_checker.sv -----
`timescale 1ns / 1ps

module tpc_checker import tpc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_pixel_out        o_out_data,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic              pready
);

    logic [1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OPAQUE;
        end else if (psel && penable && pwrite && pready
                     && t_reg_idx'(paddr[ADDR_W-1:2]) == REG_OUTPUT_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output drains");

    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_mode != MODE_KEEP |-> o_out_data.out_alpha == 8'hFF)
        else $error("alpha not opaque outside keep mode");

endmodule

bind tinted_pixel_colorizer tpc_checker u_tpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import tpc_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         LIMIT_CYCLES = 200000;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         PHASES       = 9;
    localparam int         PHASE_ITEMS  = 45;
    localparam int         PRESS_PHASE  = 3;
    localparam int         PAUSE_PHASE  = 5;

    typedef struct {
        t_cfg       cfg;
        t_pixel_in  px;
        bit         known;
        t_pixel_out want;
    } t_dir_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_pixel_in         i_in_data   = '0;
    logic              i_out_stall = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_pixel_out        o_out_data;
    logic [31:0]       prdata;
    logic              pready;

    t_pixel_out expected_pixels[$];
    t_dir_row   dir_rows[$];
    t_cfg       live_cfg     = '0;
    bit         gaps_on      = 1'b1;
    bit         calm         = 1'b0;
    int         hold_seq     = 0;
    int         pixel_errors = 0;
    int         cycle_count  = 0;
    int         stall_left   = 0;
    int         hold_left    = 0;
    int         hold_seen    = 0;

    tinted_pixel_colorizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [7:0] sat_term(int unsigned tint, int unsigned shade,
                                            int unsigned add);
        int unsigned v;
        v = ((tint * shade + 127) >> 8) + add;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] blend_term(int unsigned c, int unsigned back,
                                              int unsigned a);
        int unsigned v;
        v = ((c * a + 127) >> 8) + ((back * (256 - a) + 127) >> 8);
        return v[7:0];
    endfunction

    function automatic t_pixel_out tint_pixel(t_cfg c, t_pixel_in p);
        int unsigned gray;
        int unsigned tr;
        int unsigned tg;
        int unsigned tb;
        int unsigned add;
        t_pixel_out  r;
        if (c.disabled_look) begin
            gray = (11 * c.tint_red + 16 * c.tint_green + 5 * c.tint_blue) >> 5;
            tr   = (3 * c.tint_red + gray) >> 2;
            tg   = (3 * c.tint_green + gray) >> 2;
            tb   = (3 * c.tint_blue + gray) >> 2;
            add  = (p.highlight * gray + 127) >> 8;
        end else begin
            tr  = c.tint_red + 2;
            tg  = c.tint_green + 2;
            tb  = c.tint_blue + 2;
            add = p.highlight;
            if (p.shade != 0) begin
                add = add * 5 / 4;
            end
        end
        r.out_red   = sat_term(tr, p.shade, add);
        r.out_green = sat_term(tg, p.shade, add);
        r.out_blue  = sat_term(tb, p.shade, add);
        r.out_alpha = 8'hFF;
        if (c.output_mode == MODE_KEEP) begin
            r.out_alpha = p.coverage;
        end else if (c.output_mode == MODE_BLEND) begin
            r.out_red   = blend_term(r.out_red, c.back_red, p.coverage);
            r.out_green = blend_term(r.out_green, c.back_green, p.coverage);
            r.out_blue  = blend_term(r.out_blue, c.back_blue, p.coverage);
        end
        return r;
    endfunction

    function automatic t_cfg mk_cfg(input logic [7:0] tr, tg, tb, br, bg, bb,
                                    input logic dis, input logic [1:0] mode);
        return {tr, tg, tb, br, bg, bb, dis, mode};
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pixel_in random_pixel();
        t_pixel_in p;
        p.shade     = pick_byte();
        p.highlight = pick_byte();
        p.coverage  = pick_byte();
        return p;
    endfunction

    function automatic t_cfg random_cfg();
        return mk_cfg(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                      pick_byte(), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endfunction

    task automatic add_row(t_cfg c, logic [7:0] sh, logic [7:0] hl, logic [7:0] cv,
                           bit known, logic [31:0] want);
        t_dir_row r;
        r.cfg   = c;
        r.px    = {sh, hl, cv};
        r.known = known;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    // Upper data bits are random; the register keeps only its width.
    task automatic reg_write(t_reg_idx idx, logic [7:0] val, int w);
        logic [31:0] mask;
        logic [31:0] d;
        mask = (32'd1 << w) - 1;
        d    = $urandom;
        d    = (d & ~mask) | ({24'd0, val} & mask);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_cfg(t_cfg c);
        drain_pixels();
        repeat (3) @(posedge i_clk);
        reg_write(REG_TINT_RED, c.tint_red, 8);
        reg_write(REG_TINT_GREEN, c.tint_green, 8);
        reg_write(REG_TINT_BLUE, c.tint_blue, 8);
        reg_write(REG_BACK_RED, c.back_red, 8);
        reg_write(REG_BACK_GREEN, c.back_green, 8);
        reg_write(REG_BACK_BLUE, c.back_blue, 8);
        reg_write(REG_DISABLED_LOOK, {7'd0, c.disabled_look}, 1);
        reg_write(REG_OUTPUT_MODE, {6'd0, c.output_mode}, 2);
        live_cfg = c;
    endtask

    task automatic send_pixel(t_pixel_in p, bit known, t_pixel_out want);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (o_in_stall);
        expected_pixels.push_back(known ? want : tint_pixel(live_cfg, p));
    endtask

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h",
                         $time, o_out_data);
                pixel_errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_data.out_red !== want.out_red ||
                    o_out_data.out_green !== want.out_green ||
                    o_out_data.out_blue !== want.out_blue ||
                    o_out_data.out_alpha !== want.out_alpha) begin
                    $display("%0t: mismatch expected r%h g%h b%h a%h actual r%h g%h b%h a%h",
                             $time, want.out_red, want.out_green, want.out_blue,
                             want.out_alpha, o_out_data.out_red, o_out_data.out_green,
                             o_out_data.out_blue, o_out_data.out_alpha);
                    pixel_errors++;
                end
            end
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_cfg c_reset;
        t_cfg c_keep;
        t_cfg c_dim;
        t_cfg c_blend;
        t_cfg c_unused;
        t_cfg c_mix;
        t_cfg c_dim_keep;
        t_cfg c_bright;
        c_reset    = mk_cfg(0, 0, 0, 0, 0, 0, 1'b0, MODE_OPAQUE);
        c_keep     = mk_cfg(0, 0, 0, 0, 0, 0, 1'b0, MODE_KEEP);
        c_dim      = mk_cfg(255, 255, 255, 0, 0, 0, 1'b1, MODE_OPAQUE);
        c_blend    = mk_cfg(0, 0, 0, 255, 255, 255, 1'b0, MODE_BLEND);
        c_unused   = mk_cfg(0, 0, 0, 0, 0, 0, 1'b0, MODE_UNUSED);
        c_mix      = mk_cfg(200, 30, 120, 10, 220, 90, 1'b0, MODE_BLEND);
        c_dim_keep = mk_cfg(90, 180, 40, 0, 0, 0, 1'b1, MODE_KEEP);
        c_bright   = mk_cfg(255, 255, 255, 0, 0, 0, 1'b0, MODE_OPAQUE);

        add_row(c_reset, 8'h00, 8'h00, 8'h00, 1, 32'h000000FF);
        add_row(c_reset, 8'hFF, 8'hFF, 8'hFF, 1, 32'hFFFFFFFF);
        add_row(c_reset, 8'h00, 8'hFF, 8'h00, 1, 32'hFFFFFFFF);
        add_row(c_reset, 8'hFF, 8'h00, 8'h00, 1, 32'h020202FF);
        add_row(c_reset, 8'h01, 8'h04, 8'h00, 1, 32'h050505FF);
        add_row(c_reset, 8'h00, 8'h04, 8'h00, 1, 32'h040404FF);
        add_row(c_keep, 8'h00, 8'h00, 8'hA5, 1, 32'h000000A5);
        add_row(c_keep, 8'h00, 8'h00, 8'h5A, 1, 32'h0000005A);
        add_row(c_keep, 8'h00, 8'h00, 8'h00, 1, 32'h00000000);
        add_row(c_dim, 8'hFF, 8'h00, 8'h00, 1, 32'hFEFEFEFF);
        add_row(c_dim, 8'hFF, 8'hFF, 8'h00, 1, 32'hFFFFFFFF);
        add_row(c_dim, 8'h00, 8'h00, 8'h00, 1, 32'h000000FF);
        add_row(c_dim, 8'h80, 8'h4D, 8'h09, 0, '0);
        add_row(c_blend, 8'h00, 8'h00, 8'h00, 1, 32'hFFFFFFFF);
        add_row(c_blend, 8'h00, 8'h00, 8'hFF, 1, 32'h010101FF);
        add_row(c_blend, 8'h00, 8'h00, 8'h80, 1, 32'h7F7F7FFF);
        add_row(c_unused, 8'hFF, 8'h00, 8'h33, 1, 32'h020202FF);
        add_row(c_mix, 8'hFF, 8'hFF, 8'hC8, 0, '0);
        add_row(c_mix, 8'h64, 8'h11, 8'h01, 0, '0);
        add_row(c_dim_keep, 8'h4D, 8'hC8, 8'h21, 0, '0);
        add_row(c_dim_keep, 8'hFF, 8'hFF, 8'hFF, 0, '0);
        add_row(c_bright, 8'hFF, 8'h00, 8'h00, 1, 32'hFFFFFFFF);
        add_row(c_bright, 8'h80, 8'h00, 8'h00, 1, 32'h808080FF);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].cfg != live_cfg) begin
                apply_cfg(dir_rows[k].cfg);
            end
            send_pixel(dir_rows[k].px, dir_rows[k].known, dir_rows[k].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1) begin
                calm <= 1'b1;
                gaps_on = 1'b0;
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            apply_cfg(random_cfg());
            if (ph == PRESS_PHASE) begin
                gaps_on = 1'b0;
                hold_seq <= hold_seq + 1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) begin
                    drain_pixels();
                end
                send_pixel(random_pixel(), 0, '0);
            end
        end

        drain_pixels();
        repeat (20) @(posedge i_clk);
        if (pixel_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
